// File: hw/rtl/sha1h_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 hasher package
// Shared constants, command and status types, and round helper functions
// for the SHA-1 message hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1h_pkg;

	// Block geometry and schedule sizes.
	localparam int BLOCK_BYTES = 64;
	localparam int FILL_W      = 6;
	localparam int SCHED_WORDS = 16;
	localparam int NUM_ROUNDS  = 80;
	localparam int RND_W       = 7;
	localparam int NUM_WORDS   = 5;
	localparam int IDX_W       = 3;
	localparam int LEN_W       = 64;

	// Byte position where the message length starts in the final block.
	localparam logic [FILL_W-1:0] LEN_POS   = 6'd56;
	localparam logic [FILL_W-1:0] LAST_POS  = 6'd63;
	localparam logic [RND_W-1:0]  LAST_RND  = 7'd79;
	localparam logic [IDX_W-1:0]  LAST_IDX  = 3'd4;
	localparam logic [7:0]        PAD_MARK  = 8'h80;

	// Round constants.
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	// Initial chaining values.
	localparam logic [31:0] H_INIT [NUM_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	// Source of a byte pushed into the block buffer.
	typedef enum logic [1:0] {
		BSEL_IN   = 2'd0,
		BSEL_MARK = 2'd1,
		BSEL_ZERO = 2'd2,
		BSEL_LEN  = 2'd3
	} byte_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                push;
		byte_sel_t           byte_sel;
		logic [FILL_W-1:0]   fill;
		logic                len_inc;
		logic                load_work;
		logic                round;
		logic [RND_W-1:0]    rnd;
		logic                update_h;
		logic                finish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

	// Round logic function, selected by the round group.
	function automatic logic [31:0] round_f(input logic [RND_W-1:0] rnd,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (rnd < 7'd40) begin
			f = b ^ c ^ d;
		end else if (rnd < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	// Round constant, selected by the round group.
	function automatic logic [31:0] round_k(input logic [RND_W-1:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20) begin
			k = K0;
		end else if (rnd < 7'd40) begin
			k = K1;
		end else if (rnd < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sha1h_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 hasher controller
// State machine that accepts input bytes, sequences padding, runs the 80
// compression rounds and hands the finished digest to the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1h_ctrl
	import sha1h_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_present,
	input  wire logic     in_end,
	output logic          in_ready,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PAD   = 6'b000010,
		S_LOAD  = 6'b000100,
		S_ROUND = 6'b001000,
		S_UPD   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [RND_W-1:0]  rnd_q, rnd_d;
	logic              fin_q, fin_d;
	logic              mark_q, mark_d;
	logic              lenph_q, lenph_d;
	logic              done_q, done_d;

	// Next-state and command logic.
	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		rnd_d    = rnd_q;
		fin_d    = fin_q;
		mark_d   = mark_q;
		lenph_d  = lenph_q;
		done_d   = done_q;
		in_ready = 1'b0;

		cmd           = '0;
		cmd.byte_sel  = BSEL_IN;
		cmd.fill      = fill_q;
		cmd.rnd       = rnd_q;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					fin_d = in_end;
					if (in_present) begin
						cmd.push     = 1'b1;
						cmd.byte_sel = BSEL_IN;
						cmd.len_inc  = 1'b1;
						fill_d       = fill_q + FILL_W'(1);
					end
					if (in_present && (fill_q == LAST_POS)) begin
						state_d = S_LOAD;
					end else if (in_end) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				cmd.push = 1'b1;
				fill_d   = fill_q + FILL_W'(1);
				if (!mark_q) begin
					cmd.byte_sel = BSEL_MARK;
					mark_d       = 1'b1;
				end else if ((fill_q == LEN_POS) || lenph_q) begin
					cmd.byte_sel = BSEL_LEN;
					lenph_d      = 1'b1;
					if (fill_q == LAST_POS) begin
						done_d = 1'b1;
					end
				end else begin
					cmd.byte_sel = BSEL_ZERO;
				end
				if (fill_q == LAST_POS) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load_work = 1'b1;
				rnd_d         = '0;
				state_d       = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				rnd_d     = rnd_q + RND_W'(1);
				if (rnd_q == LAST_RND) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.update_h = 1'b1;
				if (done_q) begin
					state_d = S_OUT;
				end else if (fin_q) begin
					state_d = S_PAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					fin_d      = 1'b0;
					mark_d     = 1'b0;
					lenph_d    = 1'b0;
					done_d     = 1'b0;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			rnd_q   <= '0;
			fin_q   <= 1'b0;
			mark_q  <= 1'b0;
			lenph_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			rnd_q   <= rnd_d;
			fin_q   <= fin_d;
			mark_q  <= mark_d;
			lenph_q <= lenph_d;
			done_q  <= done_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sha1h_dp.sv
// ----------------------------------------------------------------------------
// SHA-1 hasher datapath
// Block buffer doubling as the message schedule window, working variables,
// chaining words, bit length counter and the digest output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1h_dp
	import sha1h_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	output dp_stat_t        stat,
	input  wire logic [7:0] in_byte,
	output logic [31:0]     out_word,
	output logic [IDX_W-1:0] out_index,
	output logic            out_valid,
	input  wire logic       out_ready
);

	logic [31:0]      w_q [SCHED_WORDS];
	logic [31:0]      a_q, b_q, c_q, d_q, e_q;
	logic [31:0]      h_q [NUM_WORDS];
	logic [LEN_W-1:0] len_q;
	logic [31:0]      dig_q [NUM_WORDS];
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;

	logic [7:0]  push_byte;
	logic [31:0] w_next;
	logic [31:0] t_sum;

	// Byte pushed into the block: input, pad marker, zero or length byte.
	always_comb begin
		case (cmd.byte_sel)
			BSEL_IN:   push_byte = in_byte;
			BSEL_MARK: push_byte = PAD_MARK;
			BSEL_ZERO: push_byte = 8'h00;
			BSEL_LEN:  push_byte = len_q[{~cmd.fill[2:0], 3'b000} +: 8];
			default:   push_byte = 8'h00;
		endcase
	end

	// Next schedule word and round sum.
	assign w_next = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
		w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
	assign t_sum = {a_q[26:0], a_q[31:27]} + round_f(cmd.rnd, b_q, c_q, d_q) + e_q
		+ round_k(cmd.rnd) + w_q[0];

	// Block buffer: bytes shift in big-endian, rounds shift the schedule window.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < SCHED_WORDS - 1; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[SCHED_WORDS-1] <= {w_q[SCHED_WORDS-1][23:0], push_byte};
		end else if (cmd.round) begin
			for (int i = 0; i < SCHED_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[SCHED_WORDS-1] <= w_next;
		end
	end

	// Working variables.
	always_ff @(posedge clk) begin
		if (cmd.load_work) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// Chaining words and message bit length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				h_q[i] <= H_INIT[i];
			end
			len_q <= '0;
		end else begin
			if (cmd.update_h) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end else if (cmd.finish) begin
				for (int i = 0; i < NUM_WORDS; i++) begin
					h_q[i] <= H_INIT[i];
				end
			end
			if (cmd.finish) begin
				len_q <= '0;
			end else if (cmd.len_inc) begin
				len_q <= len_q + LEN_W'(8);
			end
		end
	end

	// Digest output buffer payload: loaded at finish, shifted per transaction.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				dig_q[i] <= h_q[i];
			end
		end else if (busy_q && out_ready) begin
			for (int i = 0; i < NUM_WORDS - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
		end
	end

	// Digest output buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			busy_q <= 1'b0;
		end else if (cmd.finish) begin
			idx_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + IDX_W'(1);
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign out_word      = dig_q[0];
	assign out_index     = idx_q;
	assign out_valid     = busy_q;
	assign stat.out_busy = busy_q;

endmodule

`default_nettype wire

// File: hw/rtl/sha1_message_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-1 message hasher
// SHA-1 over a byte stream; emits the five digest words at end of message.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one transaction per message byte: tdata carries the
// byte, tuser says whether the byte is present, and tlast ends the message.
// A transaction with tlast and tuser low ends the message without a byte, so
// an empty message is allowed.
// Bytes are taken while tready is high. Each full 64-byte block then loads
// the working variables, runs 80 rounds on the single round unit and
// updates the chaining words, during all of which tready is low.
// At end of message the padding bytes are pushed one per cycle (up to 64, or
// up to 72 when a second block is needed), each block is compressed, and the
// digest goes to an output buffer once that buffer has drained.
// The master channel then gives five transactions, word 0 first, the last
// with tlast. A stalled receiver holds the buffer; the next message may be
// fed meanwhile, and its finish waits until the buffer has drained.
// Reset returns the chaining words to their initial values and clears the
// length, fill count and output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_hasher_top
	import sha1h_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Byte input channel.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic        s_axis_tuser,  // [0] byte_present
	input  wire logic        s_axis_tlast,  // end_of_message
	// Digest output channel.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // [31:0] digest_word, [34:32] word_index
	output logic             m_axis_tlast   // last_word
);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [31:0]      out_word;
	logic [IDX_W-1:0] out_index;

	// Controller.
	sha1h_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_present (s_axis_tuser),
		.in_end     (s_axis_tlast),
		.in_ready   (s_axis_tready),
		.cmd        (cmd),
		.stat       (stat)
	);

	// Datapath.
	sha1h_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_byte   (s_axis_tdata),
		.out_word  (out_word),
		.out_index (out_index),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

	// Output packing.
	assign m_axis_tdata = {5'b00000, out_index, out_word};
	assign m_axis_tlast = (out_index == LAST_IDX);

`ifndef SYNTHESIS
	// The digest buffer is only reloaded once it has drained.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !stat.out_busy)
		else $error("digest buffer reloaded while busy");

	// A byte push and a compression round never share a cycle.
	a_push_round: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.round))
		else $error("byte push during a compression round");

	// The word index of a shown digest word stays within the digest.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_index <= LAST_IDX))
		else $error("digest word index out of range");

	// After the last digest word leaves, the buffer is empty in the following cycle.
	a_last_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
		else $error("digest buffer not empty after last word");
`endif

endmodule

`default_nettype wire

// File: bench/sha1_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches both stream channels of the hasher. Every accepted input
// transaction is run through an independent SHA-1 predictor. At end of
// message the five expected digest words are queued, and each accepted output
// transaction is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------

module sha1_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] byte_present
	input  logic        s_axis_tlast,   // end_of_message
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
	input  logic        m_axis_tlast,   // last_word
	output int          fail_count,
	output int          words_pending,
	output int          words_checked
);

	// SHA-1 initial chaining values and round constants.
	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;
	localparam logic [31:0] ROUND_K0 = 32'h5A827999;
	localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
	localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
	localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam int          LENGTH_OFFSET = 56;
	localparam int          DIGEST_WORDS = 5;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	// Predictor state.
	logic [31:0]  chain_h [DIGEST_WORDS];
	logic [7:0]   block_bytes [64];
	int           fill;
	logic [63:0]  msg_bits;
	digest_word_t digest_due [$];

	int fails = 0;
	int pending = 0;
	int checked = 0;

	assign fail_count    = fails;
	assign words_pending = pending;
	assign words_checked = checked;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	task automatic restart_chain();
		chain_h[0] = IV0;
		chain_h[1] = IV1;
		chain_h[2] = IV2;
		chain_h[3] = IV3;
		chain_h[4] = IV4;
		fill = 0;
		msg_bits = '0;
	endtask

	// One SHA-1 compression of the 64 gathered bytes into the chaining words.
	task automatic compress_block();
		logic [31:0] sched [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++) begin
			sched[r] = {block_bytes[4*r], block_bytes[4*r+1],
				block_bytes[4*r+2], block_bytes[4*r+3]};
		end
		for (int r = 16; r < 80; r++) begin
			sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
		end
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = ROUND_K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = ROUND_K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = ROUND_K2;
			end else begin
				f = b ^ c ^ d;
				k = ROUND_K3;
			end
			t = rotl(a, 5) + f + e + k + sched[r];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endtask

	task automatic absorb_byte(input logic [7:0] value);
		block_bytes[fill] = value;
		fill++;
		if (fill == 64) begin
			compress_block();
			fill = 0;
		end
	endtask

	// Pad the message, finish the hash and queue the five digest words.
	task automatic finish_message();
		logic [63:0]  length_bits;
		digest_word_t entry;
		length_bits = msg_bits;
		absorb_byte(PAD_BYTE);
		while (fill != LENGTH_OFFSET) begin
			absorb_byte(8'h00);
		end
		for (int i = 0; i < 8; i++) begin
			absorb_byte(length_bits[63-8*i -: 8]);
		end
		for (int i = 0; i < DIGEST_WORDS; i++) begin
			entry.word  = chain_h[i];
			entry.index = 3'(i);
			entry.last  = (i == DIGEST_WORDS - 1);
			digest_due.push_back(entry);
		end
		restart_chain();
	endtask

	// Compare one digest transaction with the oldest expected word.
	task automatic check_digest_word();
		digest_word_t exp_word;
		if (digest_due.size() == 0) begin
			fails++;
			$display("%0t: unexpected digest transaction, got word %h index %0d last %b",
				$time, m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
		end else begin
			exp_word = digest_due.pop_front();
			checked++;
			if (m_axis_tdata[31:0] !== exp_word.word) begin
				fails++;
				$display("%0t: digest word mismatch, expected %h, got %h",
					$time, exp_word.word, m_axis_tdata[31:0]);
			end
			if (m_axis_tdata[34:32] !== exp_word.index) begin
				fails++;
				$display("%0t: word index mismatch, expected %0d, got %0d",
					$time, exp_word.index, m_axis_tdata[34:32]);
			end
			if (m_axis_tlast !== exp_word.last) begin
				fails++;
				$display("%0t: last word flag mismatch, expected %b, got %b",
					$time, exp_word.last, m_axis_tlast);
			end
		end
	endtask

	// Both channels are sampled at the same edge at which the block samples them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_chain();
			digest_due.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_digest_word();
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser) begin
					msg_bits += 64'd8;
					absorb_byte(s_axis_tdata);
				end
				if (s_axis_tlast) begin
					finish_message();
				end
			end
		end
		pending = digest_due.size();
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message hasher testbench
// Feeds byte messages of many lengths into the hasher and lets the digest
// checker predict and compare every output word. Directed messages come
// first, then random messages under three idling profiles.
// ----------------------------------------------------------------------------

module tb;

	localparam int LIMIT_CYCLES = 300000;
	localparam int PHASE_ITEMS  = 80;
	localparam int SETTLE_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	int fail_count;
	int words_pending;
	int words_checked;

	int sender_gap_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int msgs_hashed = 0;
	int bytes_hashed = 0;
	int longest_msg = 0;

	always #2 clk = ~clk;

	sha1_message_hasher_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	sha1_digest_checker digest_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.words_pending (words_pending),
		.words_checked (words_checked)
	);

	// Receiver back-pressure at the rate of the current profile.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Run timed out after %0d cycles with %0d digest words outstanding",
				cycle_count, words_pending);
			$display("Some tests failed");
			$finish;
		end
	end

	// One input transaction, preceded by random idle cycles.
	task automatic put_item(input logic [7:0] value, input logic present, input logic ends);
		while ($urandom_range(99) < sender_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= present;
		s_axis_tlast  <= ends;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		if (present || ends) begin
			items_sent++;
		end
		if (present) begin
			bytes_hashed++;
		end
		if (ends) begin
			msgs_hashed++;
		end
	endtask

	// A message of random bytes, with the odd ignored transaction mixed in.
	task automatic put_message(input int len);
		logic end_on_byte;
		end_on_byte = (len != 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(11) == 0) begin
				put_item(8'($urandom), 1'b0, 1'b0);
			end
			put_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
		end
		if (!end_on_byte) begin
			put_item(8'($urandom), 1'b0, 1'b1);
		end
		if (len > longest_msg) begin
			longest_msg = len;
		end
	endtask

	// Hold the sender off until every digest word has come back. The first
	// edge lets the checker queue the words of the last accepted message.
	task automatic drain_digests();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int phase_start;
		int len;
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_gap_pct = 8;
		recv_stall_pct = 82;

		// Empty message: end without a byte.
		put_item(8'h00, 1'b0, 1'b1);
		// "abc" with the last byte carried on the end transaction.
		put_item(8'h61, 1'b1, 1'b0);
		put_item(8'h62, 1'b1, 1'b0);
		put_item(8'h63, 1'b1, 1'b1);
		// Extreme bytes, an ignored transaction in between, separate end.
		put_item(8'h00, 1'b1, 1'b0);
		put_item(8'hA5, 1'b0, 1'b0);
		put_item(8'hFF, 1'b1, 1'b0);
		put_item(8'h5A, 1'b0, 1'b1);
		// Single byte together with end.
		put_item(8'hFF, 1'b1, 1'b1);
		put_item(8'h80, 1'b1, 1'b1);
		drain_digests();

		// Random messages under three idling profiles. Each profile opens with
		// one long message: padding overflow, exact fit, then a full block or 120 bytes.
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				sender_gap_pct = 82;
				recv_stall_pct = 8;
			end else if (phase == 2) begin
				sender_gap_pct = 0;
				recv_stall_pct = 0;
			end
			phase_start = items_sent;
			if (phase == 0) begin
				len = $urandom_range(56, 63);
			end else if (phase == 1) begin
				len = ($urandom_range(1) == 1) ? 55 : 119;
			end else begin
				len = ($urandom_range(1) == 1) ? 64 : 120;
			end
			put_message(len);
			while (items_sent - phase_start < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 65) begin
					len = $urandom_range(0, 8);
				end else begin
					len = $urandom_range(9, 40);
				end
				put_message(len);
			end
			if (phase == 0) begin
				drain_digests();
			end
		end

		drain_digests();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Hashed %0d messages, %0d bytes, longest %0d bytes; %0d digest words checked.",
			msgs_hashed, bytes_hashed, longest_msg, words_checked);
		$display("Covered empty messages, end with and without a byte, padding overflow,",
			" multi-block messages and both-sided stalls.");
		if (fail_count == 0 && words_pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
